[rtl/pfc_pkg.sv]
// shared types and constants of the prime factorization core
`default_nettype none

package pfc_pkg;

    // default width of the value to factor
    localparam int VALUE_WIDTH_DEF = 31;

    // field widths of one result item
    localparam int PRIME_W = 31;
    localparam int EXP_W   = 5;

    // most result items one value can produce
    localparam int MAX_RESULTS = 9;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    // first odd trial divisor and its square
    localparam int FIRST_ODD    = 3;
    localparam int FIRST_ODD_SQ = FIRST_ODD * FIRST_ODD;

    // one result item
    typedef struct packed {
        logic [PRIME_W-1:0] prime;
        logic [EXP_W-1:0]   exponent;
        logic               last;
        logic               no_factors;
    } result_t;

endpackage

`default_nettype wire

[rtl/pfc_divider.sv]
// restoring divider, one quotient bit per cycle
`default_nettype none

module pfc_divider #(
    parameter int DIVIDEND_W = pfc_pkg::VALUE_WIDTH_DEF,
    parameter int DIVISOR_W  = (pfc_pkg::VALUE_WIDTH_DEF + 1) / 2 + 1
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic [DIVIDEND_W-1:0]      quotient,
    output logic [DIVISOR_W-1:0]       remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;

    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    diff;

    // shift in the next dividend bit and try to subtract
    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff      = rem_shift - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (!diff[DIVISOR_W]) begin
                rem_next = diff[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

[rtl/prime_factorization_core.sv]
// trial division prime factorization core, top level
`default_nettype none

// channel   ports                                         direction
// input     s_valid s_ready s_value                       in
// result    m_valid m_ready m_prime m_exponent m_last      out
//           m_no_factors
//
// one value at a time; s_ready is high only while no value is in work
// each odd divisor tried costs one division by the shared divider; n tries up to
// sqrt(n) / 2 divisors, one more division per odd prime factor occurrence; factors of
// two are stripped by shifting, with no division
// a stalled result channel holds the search once two results wait, and holds the final
// result; reset is synchronous and clears control

module prime_factorization_core #(
    parameter int VALUE_WIDTH = pfc_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [VALUE_WIDTH-1:0]      s_value,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [pfc_pkg::PRIME_W-1:0]      m_prime,
    output logic [pfc_pkg::EXP_W-1:0]        m_exponent,
    output logic                             m_last,
    output logic                             m_no_factors
);

    localparam int DIV_W  = (VALUE_WIDTH + 1) / 2 + 1;
    localparam int SQ_W   = VALUE_WIDTH + 1;
    localparam int EXPC_W = $clog2(VALUE_WIDTH);
    localparam int RCW    = pfc_pkg::RES_CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TWOS,
        ST_CHECK,
        ST_DIVIDE,
        ST_TEST,
        ST_FINISH,
        ST_FLUSH
    } state_t;

    state_t                   state_reg, state_next;
    logic [VALUE_WIDTH-1:0]   rest_reg, rest_next;
    logic [DIV_W-1:0]         d_reg, d_next;
    logic [SQ_W-1:0]          sq_reg, sq_next;
    logic [EXPC_W-1:0]        count_reg, count_next;
    logic [RCW-1:0]           k_reg, k_next;
    logic                     start_reg, start_next;
    logic                     pend_valid_reg, pend_valid_next;
    pfc_pkg::result_t         pend_reg, pend_next;
    logic                     out_valid_reg, out_valid_next;
    pfc_pkg::result_t         out_reg, out_next;

    logic                     div_done;
    logic [VALUE_WIDTH-1:0]   div_quo;
    logic [DIV_W-1:0]         div_rem;

    logic                     out_free;
    logic                     push_ok;
    logic                     room;
    logic                     rec_do;
    pfc_pkg::result_t         rec_item;

    // shared remainder unit
    pfc_divider #(
        .DIVIDEND_W (VALUE_WIDTH),
        .DIVISOR_W  (DIV_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start_reg),
        .dividend  (rest_reg),
        .divisor   (d_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // a new factor may go to the pending slot when that slot is empty or can drain
    assign out_free = !out_valid_reg || m_ready;
    assign push_ok  = !pend_valid_reg || out_free;
    assign room     = k_reg < RCW'(pfc_pkg::MAX_RESULTS);

    always_comb begin
        state_next      = state_reg;
        rest_next       = rest_reg;
        d_next          = d_reg;
        sq_next         = sq_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        start_next      = 1'b0;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        rec_do          = 1'b0;
        rec_item        = '0;

        // result register drains on its own
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    rest_next  = s_value;
                    d_next     = DIV_W'(pfc_pkg::FIRST_ODD);
                    sq_next    = SQ_W'(pfc_pkg::FIRST_ODD_SQ);
                    count_next = '0;
                    k_next     = '0;
                    if (s_value <= VALUE_WIDTH'(1)) begin
                        pend_next.prime      = '0;
                        pend_next.exponent   = '0;
                        pend_next.last       = 1'b1;
                        pend_next.no_factors = 1'b1;
                        pend_valid_next      = 1'b1;
                        state_next           = ST_FLUSH;
                    end else begin
                        state_next = ST_TWOS;
                    end
                end
            end
            // strip factors of two one bit a cycle
            ST_TWOS: begin
                if (!rest_reg[0]) begin
                    rest_next  = rest_reg >> 1;
                    count_next = count_reg + EXPC_W'(1);
                end else if (count_reg == '0 || !room || push_ok) begin
                    if (count_reg != '0 && room) begin
                        rec_do            = 1'b1;
                        rec_item.prime    = pfc_pkg::PRIME_W'(2);
                        rec_item.exponent = pfc_pkg::EXP_W'(count_reg);
                    end
                    count_next = '0;
                    state_next = ST_CHECK;
                end
            end
            // keep going while divisor squared fits in the rest
            ST_CHECK: begin
                if (sq_reg > {1'b0, rest_reg}) begin
                    state_next = ST_FINISH;
                end else begin
                    start_next = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                if (div_rem == '0) begin
                    rest_next  = div_quo;
                    count_next = count_reg + EXPC_W'(1);
                    start_next = 1'b1;
                    state_next = ST_DIVIDE;
                end else if (count_reg == '0 || !room || push_ok) begin
                    if (count_reg != '0 && room) begin
                        rec_do            = 1'b1;
                        rec_item.prime    = pfc_pkg::PRIME_W'(d_reg);
                        rec_item.exponent = pfc_pkg::EXP_W'(count_reg);
                    end
                    count_next = '0;
                    // (d + 2)^2 = d^2 + 4d + 4
                    d_next     = d_reg + DIV_W'(2);
                    sq_next    = sq_reg + (SQ_W'(d_reg) << 2) + SQ_W'(4);
                    state_next = ST_CHECK;
                end
            end
            // leftover above one is a prime of its own
            ST_FINISH: begin
                if (rest_reg > VALUE_WIDTH'(1) && room) begin
                    if (push_ok) begin
                        rec_do            = 1'b1;
                        rec_item.prime    = pfc_pkg::PRIME_W'(rest_reg);
                        rec_item.exponent = pfc_pkg::EXP_W'(1);
                        state_next        = ST_FLUSH;
                    end
                end else begin
                    state_next = ST_FLUSH;
                end
            end
            // final result carries the last mark
            ST_FLUSH: begin
                if (out_free) begin
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // new factor: move the pending one out and hold the new one
        if (rec_do) begin
            if (pend_valid_reg) begin
                out_next       = pend_reg;
                out_valid_next = 1'b1;
            end
            pend_next       = rec_item;
            pend_valid_next = 1'b1;
            k_next          = k_reg + RCW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            start_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            k_reg          <= '0;
        end else begin
            state_reg      <= state_next;
            start_reg      <= start_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            k_reg          <= k_next;
        end
        rest_reg  <= rest_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
        count_reg <= count_next;
        pend_reg  <= pend_next;
        out_reg   <= out_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = out_valid_reg;
    assign m_prime      = out_reg.prime;
    assign m_exponent   = out_reg.exponent;
    assign m_last       = out_reg.last;
    assign m_no_factors = out_reg.no_factors;

    // a new item never finds a result still pending
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !pend_valid_reg)
        else $error("item accepted with a pending result");

    // divider finishes only while the sequencer waits for it
    a_done_in_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIVIDE))
        else $error("divider done outside of divide state");

    // never more results than allowed
    a_result_count: assert property (@(posedge aclk) disable iff (!aresetn)
        k_reg <= RCW'(pfc_pkg::MAX_RESULTS))
        else $error("result count overflow");

    // trial divisors stay odd
    a_odd_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) |-> d_reg[0])
        else $error("even trial divisor");

    // flushing puts the last-marked result on the output
    a_flush_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH && out_free) |=> (m_valid && m_last))
        else $error("flush did not present the last result");

endmodule

`default_nettype wire

[sim/tb_prime_factorization_core.sv]
// testbench for the trial division prime factorization core
`timescale 1ns / 1ps

module tb_prime_factorization_core;

    localparam int VALUE_W = pfc_pkg::VALUE_WIDTH_DEF;
    localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_W) - 1;
    localparam int IDLE_PCT = 23;
    localparam int RANDOM_ITEMS = 81;
    localparam int DRAIN_CYCLES = 50;
    localparam longint unsigned CYCLE_LIMIT = 64'd6_000_000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [VALUE_W-1:0] s_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [pfc_pkg::PRIME_W-1:0] m_prime;
    logic [pfc_pkg::EXP_W-1:0] m_exponent;
    logic m_last;
    logic m_no_factors;

    // factors still owed by the core, oldest first
    pfc_pkg::result_t pending_factors[$];
    int unsigned mismatch_count = 0;
    longint unsigned cycle_count = 0;
    bit idle_on = 1'b1;

    prime_factorization_core #(
        .VALUE_WIDTH(VALUE_W)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_value(s_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_prime(m_prime),
        .m_exponent(m_exponent),
        .m_last(m_last),
        .m_no_factors(m_no_factors)
    );

    // clock, 2 ns period
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles", $time, cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // trial division: twos first, then odd divisors up to the square root
    function automatic void predict_factors(input logic [VALUE_W-1:0] value);
        longint unsigned rest;
        longint unsigned divisor;
        int unsigned count;
        pfc_pkg::result_t factor;
        pfc_pkg::result_t found[$];
        rest = 64'(value);
        factor = '0;
        if (rest <= 1) begin
            factor.last = 1'b1;
            factor.no_factors = 1'b1;
            pending_factors = {pending_factors, factor};
            return;
        end
        if (rest[0] == 1'b0) begin
            count = 0;
            while (rest[0] == 1'b0) begin
                rest = rest >> 1;
                count++;
            end
            factor.prime = pfc_pkg::PRIME_W'(2);
            factor.exponent = count[pfc_pkg::EXP_W-1:0];
            found = {found, factor};
        end
        for (divisor = 3; divisor * divisor <= rest; divisor += 2) begin
            if (rest % divisor == 0) begin
                count = 0;
                while (rest % divisor == 0) begin
                    rest = rest / divisor;
                    count++;
                end
                if (found.size() < pfc_pkg::MAX_RESULTS) begin
                    factor.prime = divisor[pfc_pkg::PRIME_W-1:0];
                    factor.exponent = count[pfc_pkg::EXP_W-1:0];
                    found = {found, factor};
                end
            end
        end
        // leftover above one is a prime of its own
        if (rest > 1 && found.size() < pfc_pkg::MAX_RESULTS) begin
            factor.prime = rest[pfc_pkg::PRIME_W-1:0];
            factor.exponent = pfc_pkg::EXP_W'(1);
            found = {found, factor};
        end
        found[found.size() - 1].last = 1'b1;
        pending_factors = {pending_factors, found};
    endfunction

    // send one item; entered and left just after a falling edge
    task automatic send_value(input logic [VALUE_W-1:0] value);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_value = value;
        do @(posedge aclk); while (!s_ready);
        predict_factors(value);
        @(negedge aclk);
    endtask

    // result side back-pressure
    always @(negedge aclk) begin
        m_ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic report_field(input string field, input longint unsigned want,
                                input longint unsigned got);
        if (want != got) begin
            $display("%0t %s mismatch: expected %0d actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // compare each result item with the oldest expectation
    always @(posedge aclk) begin : check_results
        pfc_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_factors.size() == 0) begin
                $display("%0t unexpected item: expected none actual prime %0d exp %0d",
                         $time, m_prime, m_exponent);
                mismatch_count++;
            end else begin
                want = pending_factors.pop_front();
                report_field("prime", want.prime, m_prime);
                report_field("exponent", want.exponent, m_exponent);
                report_field("last", want.last, m_last);
                report_field("no_factors", want.no_factors, m_no_factors);
            end
        end
    end

    // zero and one have no factors
    task automatic test_no_factors();
        send_value(VALUE_W'(0));
        send_value(VALUE_W'(1));
    endtask

    // pure prime powers, up to the widest exponent
    task automatic test_prime_powers();
        send_value(VALUE_W'(2));
        send_value(VALUE_W'(4));
        send_value(VALUE_W'(49));
        send_value(VALUE_W'(961));
        send_value(VALUE_W'(64'd1 << 30));
        send_value(VALUE_W'(64'd1162261467));
    endtask

    // primes, including the top of the range
    task automatic test_primes();
        send_value(VALUE_W'(3));
        send_value(VALUE_W'(97));
        send_value(VALUE_W'(65521));
        send_value(VALUE_W'(VALUE_MAX));
    endtask

    // composites, including the most distinct primes a value can hold
    task automatic test_composites();
        send_value(VALUE_W'(12));
        send_value(VALUE_W'(360));
        send_value(VALUE_W'(1001));
        send_value(VALUE_W'(64'd223092870));
        send_value(VALUE_W'(64'd2147483646));
        send_value(VALUE_W'(64'd1073741825));
        send_value(VALUE_W'(64'd2147483640));
    endtask

    // product of small random factors, kept within the value width
    function automatic logic [VALUE_W-1:0] smooth_value();
        longint unsigned acc;
        longint unsigned factor;
        int unsigned steps;
        acc = 1;
        steps = $urandom_range(1, 14);
        for (int k = 0; k < steps; k++) begin
            factor = 64'($urandom_range(2, 200));
            if (acc * factor <= VALUE_MAX) acc = acc * factor;
        end
        return acc[VALUE_W-1:0];
    endfunction

    // random values: mostly smooth products, some small raw values
    task automatic test_random_values();
        int unsigned pick;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_on = !(n >= 40 && n < 70);
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_value(smooth_value());
            else if (pick < 85)
                send_value(VALUE_W'($urandom_range(0, 65535)));
            else
                send_value(VALUE_W'($urandom_range(65536, 262143)));
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_no_factors();
        test_prime_powers();
        test_primes();
        test_composites();
        test_random_values();
        s_valid = 1'b0;
        while (pending_factors.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
